// ===== rtl/core/dcf_pkg.sv =====
// Shared types, constants and month tables for the date to calendar fields pipeline.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package dcf_pkg;

    localparam int unsigned DayW   = 5;
    localparam int unsigned MonW   = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned OrdW   = 9;
    localparam int unsigned WdayW  = 3;
    localparam int unsigned WeekW  = 6;
    localparam int unsigned TotalW = 15;

    localparam logic [YearW-1:0] BASE_YEAR         = 14'd1900;
    // Leap years counted in 1..1899
    localparam logic [TotalW-1:0] LEAPS_BEFORE_BASE = 15'd460;

    // floor(x / 25) = (x * RECIP25) >> RECIP25_SHIFT for x below 43690
    localparam logic [12:0] RECIP25       = 13'd5243;
    localparam int unsigned RECIP25_SHIFT = 17;
    // floor(x / 7) = (x * RECIP7) >> RECIP7_SHIFT for x below 682
    localparam logic [8:0]  RECIP7        = 9'd293;
    localparam int unsigned RECIP7_SHIFT  = 11;

    localparam logic [MonW-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MonW-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MonW-1:0]  MONTH_DEC = 4'd12;
    localparam logic [WdayW-1:0] WDAY_THU  = 3'd3;

    // First stage beat: raw date, (year - 1) / 4 and the two quotient products
    typedef struct packed {
        logic             vld;
        logic [DayW-1:0]  day;
        logic [MonW-1:0]  mon;
        logic [YearW-1:0] year;
        logic [11:0]      q4;    // (year - 1) / 4
        logic [9:0]       q25;   // year / 25
        logic [7:0]       q100;  // (year - 1) / 100
    } front_t;

    // Second stage beat: check result, ordinal day, day count mod nothing yet
    typedef struct packed {
        logic              vld;
        logic              ok;
        logic [OrdW-1:0]   ord;
        logic [TotalW-1:0] total;  // days from 1 Jan 1900 to 1 Jan year, mod 7 equivalent
    } check_t;

    // Days in a month, leap February included; zero for codes that are no month
    function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] mon,
                                                   input logic leap);
        logic [DayW-1:0] len;
        len = '0;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // Days in the months before this one in a common year
    function automatic logic [OrdW-1:0] days_before(input logic [MonW-1:0] mon);
        logic [OrdW-1:0] acc;
        acc = '0;
        unique case (mon)
            4'd1:    acc = 9'd0;
            4'd2:    acc = 9'd31;
            4'd3:    acc = 9'd59;
            4'd4:    acc = 9'd90;
            4'd5:    acc = 9'd120;
            4'd6:    acc = 9'd151;
            4'd7:    acc = 9'd181;
            4'd8:    acc = 9'd212;
            4'd9:    acc = 9'd243;
            4'd10:   acc = 9'd273;
            4'd11:   acc = 9'd304;
            4'd12:   acc = 9'd334;
            default: acc = '0;
        endcase
        return acc;
    endfunction

endpackage

// ===== rtl/core/dcf_front.sv =====
// Stage 1: registers the date and the reciprocal products for year / 25 and (year - 1) / 100.
// Depends on dcf_pkg.
module dcf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [dcf_pkg::DayW-1:0]      day_num,
    input  logic [dcf_pkg::MonW-1:0]      month_num,
    input  logic [dcf_pkg::YearW-1:0]     year_num,
    output dcf_pkg::front_t               front
);

    logic [dcf_pkg::YearW-1:0] prev_year;
    logic [11:0]               q4;
    logic [24:0]               prod100;
    logic [26:0]               prod25;
    dcf_pkg::front_t           front_reg;
    dcf_pkg::front_t           front_next;

    // Quotients by reciprocal multiply; (y-1)/100 taken as ((y-1)/4)/25
    assign prev_year = year_num - 14'd1;
    assign q4        = prev_year[13:2];
    assign prod100   = 25'(q4) * 25'(dcf_pkg::RECIP25);
    assign prod25    = 27'(year_num) * 27'(dcf_pkg::RECIP25);

    always_comb
    begin
        front_next      = '0;
        front_next.vld  = in_vld;
        front_next.day  = day_num;
        front_next.mon  = month_num;
        front_next.year = year_num;
        front_next.q4   = q4;
        front_next.q25  = prod25[26:dcf_pkg::RECIP25_SHIFT];
        front_next.q100 = prod100[24:dcf_pkg::RECIP25_SHIFT];
    end

    // Stage register; reset clears the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// ===== rtl/core/dcf_check.sv =====
// Stage 2: leap rule, date check, ordinal day and day count up to 1 January of the year.
// Depends on dcf_pkg.
module dcf_check (
    input  logic             clk,
    input  logic             rst_n,
    input  dcf_pkg::front_t  front,
    output dcf_pkg::check_t  chk
);

    logic [dcf_pkg::YearW-1:0]  y25_back;
    logic                       div4;
    logic                       div16;
    logic                       div25;
    logic                       leap;
    logic [dcf_pkg::DayW-1:0]   mlen;
    logic                       ok;
    logic [dcf_pkg::YearW-1:0]  ydiff;
    logic [dcf_pkg::TotalW-1:0] leaps;
    dcf_pkg::check_t            chk_reg;
    dcf_pkg::check_t            chk_next;

    // Divisibility: by 100 is by 4 and 25, by 400 is by 16 and 25
    assign y25_back = 14'({4'd0, front.q25} * 14'd25);
    assign div4     = (front.year[1:0] == 2'd0);
    assign div16    = (front.year[3:0] == 4'd0);
    assign div25    = (front.year == y25_back);
    assign leap     = (div4 && !div25) || (div16 && div25);

    // Date check
    assign mlen = dcf_pkg::month_days(front.mon, leap);
    assign ok   = (front.mon >= dcf_pkg::MONTH_JAN) && (front.mon <= dcf_pkg::MONTH_DEC)
                  && (front.year >= dcf_pkg::BASE_YEAR) && (front.day != '0)
                  && (front.day <= mlen);

    // Leap years in 1..year-1, and day count since 1 Jan 1900 reduced by 364 per year
    assign leaps = 15'(front.q4) - 15'(front.q100) + 15'(front.q100[7:2]);
    assign ydiff = front.year - dcf_pkg::BASE_YEAR;

    always_comb
    begin
        chk_next       = '0;
        chk_next.vld   = front.vld;
        chk_next.ok    = ok;
        chk_next.ord   = dcf_pkg::days_before(front.mon) + 9'(front.day)
                         + 9'(leap && (front.mon > dcf_pkg::MONTH_FEB));
        chk_next.total = 15'(ydiff) + leaps - dcf_pkg::LEAPS_BEFORE_BASE;
    end

    // Stage register; reset clears the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg <= '0;
        end
        else
        begin
            chk_reg <= chk_next;
        end
    end

    assign chk = chk_reg;

endmodule

// ===== rtl/core/dcf_week.sv =====
// Stages 3 and 4: weekday of 1 January by octal digit folding, then weekday and week number.
// Depends on dcf_pkg.
module dcf_week (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dcf_pkg::check_t               chk,
    output logic                          done,
    output logic                          date_valid,
    output logic [dcf_pkg::OrdW-1:0]      ordinal_day,
    output logic [dcf_pkg::WdayW-1:0]     weekday,
    output logic [dcf_pkg::WeekW-1:0]     week_number
);

    logic [5:0]                 fold1;
    logic [3:0]                 fold2;
    logic [dcf_pkg::WdayW-1:0]  jan1_next;
    logic                       vld3_reg;
    logic                       ok3_reg;
    logic [dcf_pkg::OrdW-1:0]   ord3_reg;
    logic [dcf_pkg::WdayW-1:0]  jan1_reg;

    logic [dcf_pkg::OrdW-1:0]   span;
    logic [17:0]                prod7;
    logic [6:0]                 wk0;
    logic [dcf_pkg::OrdW-1:0]   rem;
    logic                       done_reg;
    logic                       date_valid_reg;
    logic [dcf_pkg::OrdW-1:0]   ordinal_day_reg;
    logic [dcf_pkg::WdayW-1:0]  weekday_reg;
    logic [dcf_pkg::WeekW-1:0]  week_number_reg;
    logic                       date_valid_next;
    logic [dcf_pkg::OrdW-1:0]   ordinal_day_next;
    logic [dcf_pkg::WdayW-1:0]  weekday_next;
    logic [dcf_pkg::WeekW-1:0]  week_number_next;

    // total mod 7: 8 is 1 mod 7, so octal digits add up
    assign fold1 = 6'(chk.total[2:0]) + 6'(chk.total[5:3]) + 6'(chk.total[8:6])
                   + 6'(chk.total[11:9]) + 6'(chk.total[14:12]);
    assign fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    assign jan1_next = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= chk.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        ok3_reg  <= chk.ok;
        ord3_reg <= chk.ord;
        jan1_reg <= jan1_next;
    end

    // Days since the Monday of the week holding 1 January, split by 7
    assign span  = ord3_reg - 9'd1 + 9'(jan1_reg);
    assign prod7 = 18'(span) * 18'(dcf_pkg::RECIP7);
    assign wk0   = prod7[17:dcf_pkg::RECIP7_SHIFT];
    assign rem   = span - (9'(wk0) * 9'd7);

    // Week 1 holds the first Thursday; invalid dates read all zero
    always_comb
    begin
        date_valid_next  = ok3_reg;
        ordinal_day_next = '0;
        weekday_next     = '0;
        week_number_next = '0;
        if (ok3_reg)
        begin
            ordinal_day_next = ord3_reg;
            weekday_next     = rem[2:0];
            week_number_next = 6'(wk0) + 6'(jan1_reg <= dcf_pkg::WDAY_THU);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        date_valid_reg  <= date_valid_next;
        ordinal_day_reg <= ordinal_day_next;
        weekday_reg     <= weekday_next;
        week_number_reg <= week_number_next;
    end

    assign done        = done_reg;
    assign date_valid  = date_valid_reg;
    assign ordinal_day = ordinal_day_reg;
    assign weekday     = weekday_reg;
    assign week_number = week_number_reg;

    // Invalid beats carry zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !date_valid_reg |->
            (ordinal_day_reg == '0) && (weekday_reg == '0) && (week_number_reg == '0))
        else $error("invalid date beat with nonzero fields");

    // Valid beats stay in range
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && date_valid_reg |->
            (weekday_reg <= 3'd6) && (week_number_reg <= 6'd53)
            && (ordinal_day_reg != '0) && (ordinal_day_reg <= 9'd366))
        else $error("valid date beat out of range");

    // Folded weekday of 1 January is a true remainder
    a_jan1_mod: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg |-> (jan1_reg <= 3'd6))
        else $error("weekday of 1 January out of range");

endmodule

// ===== rtl/core/date_to_calendar_fields.sv =====
// Date to calendar fields: the result beat is on the ports after the last register stage,
// marked by done for one cycle.
// Throughput one date per cycle; busy is always low since no stage ever holds.
// Four register stages: products, check and day count, Jan 1 weekday, week fields.
// Reset (rst_n, async, active low) clears the valid bits; no date in flight survives it.
// Depends on dcf_pkg, dcf_front, dcf_check, dcf_week.
module date_to_calendar_fields (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dcf_pkg::DayW-1:0]      day_num,
    input  logic [dcf_pkg::MonW-1:0]      month_num,
    input  logic [dcf_pkg::YearW-1:0]     year_num,
    output logic                          done,
    output logic                          date_valid,
    output logic [dcf_pkg::OrdW-1:0]      ordinal_day,
    output logic [dcf_pkg::WdayW-1:0]     weekday,
    output logic [dcf_pkg::WeekW-1:0]     week_number
);

    dcf_pkg::front_t front;
    dcf_pkg::check_t chk;
    logic            accept;

    // Pipeline takes a beat every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    dcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (accept),
        .day_num   (day_num),
        .month_num (month_num),
        .year_num  (year_num),
        .front     (front)
    );

    dcf_check u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .front (front),
        .chk   (chk)
    );

    dcf_week u_week (
        .clk         (clk),
        .rst_n       (rst_n),
        .chk         (chk),
        .done        (done),
        .date_valid  (date_valid),
        .ordinal_day (ordinal_day),
        .weekday     (weekday),
        .week_number (week_number)
    );

    // Every accepted date produces a result beat marked by done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted date produced no result beat");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for date_to_calendar_fields: directed date table, then random bursts.
// Needs dcf_pkg and the date_to_calendar_fields RTL; checks results by row or by model.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RANDOM_DATES   = 800;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_GAP        = 8;

    // One result beat as it appears on the ports
    typedef struct packed {
        logic                        valid;
        logic [dcf_pkg::OrdW-1:0]    ord;
        logic [dcf_pkg::WdayW-1:0]   wday;
        logic [dcf_pkg::WeekW-1:0]   week;
    } cal_fields_t;

    // Directed row; fixed = 1 means the expected fields are given in the row
    typedef struct {
        logic [dcf_pkg::DayW-1:0]  day;
        logic [dcf_pkg::MonW-1:0]  mon;
        logic [dcf_pkg::YearW-1:0] year;
        bit                        fixed;
        cal_fields_t               fields;
    } date_row_t;

    localparam cal_fields_t REJECTED = '0;
    localparam int unsigned NUM_ROWS = 24;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [dcf_pkg::DayW-1:0]    day_num;
    logic [dcf_pkg::MonW-1:0]    month_num;
    logic [dcf_pkg::YearW-1:0]   year_num;
    logic                        done;
    logic                        date_valid;
    logic [dcf_pkg::OrdW-1:0]    ordinal_day;
    logic [dcf_pkg::WdayW-1:0]   weekday;
    logic [dcf_pkg::WeekW-1:0]   week_number;

    cal_fields_t pending_fields[$];
    int unsigned fail_count;
    int unsigned dates_sent;
    int unsigned valid_seen;
    int unsigned rejected_seen;
    int unsigned week0_seen;
    int unsigned week53_seen;
    int unsigned quiet_cycles;

    date_row_t directed_dates [NUM_ROWS] = '{
        '{5'd1,  4'd1,  14'd1900,  1'b1, '{1'b1, 9'd1, 3'd0, 6'd1}},
        '{5'd31, 4'd12, 14'd1900,  1'b0, REJECTED},
        '{5'd1,  4'd0,  14'd2000,  1'b1, REJECTED},
        '{5'd15, 4'd13, 14'd2000,  1'b1, REJECTED},
        '{5'd31, 4'd15, 14'd16383, 1'b1, REJECTED},
        '{5'd0,  4'd6,  14'd2000,  1'b1, REJECTED},
        '{5'd0,  4'd0,  14'd0,     1'b1, REJECTED},
        '{5'd31, 4'd4,  14'd2001,  1'b1, REJECTED},
        '{5'd31, 4'd1,  14'd1899,  1'b1, REJECTED},
        '{5'd29, 4'd2,  14'd1900,  1'b1, REJECTED},
        '{5'd29, 4'd2,  14'd2000,  1'b0, REJECTED},
        '{5'd29, 4'd2,  14'd2001,  1'b1, REJECTED},
        '{5'd29, 4'd2,  14'd2004,  1'b0, REJECTED},
        '{5'd28, 4'd2,  14'd2100,  1'b0, REJECTED},
        '{5'd29, 4'd2,  14'd2100,  1'b1, REJECTED},
        '{5'd31, 4'd12, 14'd2000,  1'b0, REJECTED},
        '{5'd1,  4'd1,  14'd2021,  1'b0, REJECTED},
        '{5'd3,  4'd1,  14'd2021,  1'b0, REJECTED},
        '{5'd4,  4'd1,  14'd2021,  1'b0, REJECTED},
        '{5'd1,  4'd1,  14'd2023,  1'b0, REJECTED},
        '{5'd31, 4'd12, 14'd2020,  1'b0, REJECTED},
        '{5'd31, 4'd12, 14'd16383, 1'b0, REJECTED},
        '{5'd1,  4'd1,  14'd9999,  1'b0, REJECTED},
        '{5'd31, 4'd12, 14'd9999,  1'b0, REJECTED}
    };

    date_to_calendar_fields u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .day_num     (day_num),
        .month_num   (month_num),
        .year_num    (year_num),
        .done        (done),
        .date_valid  (date_valid),
        .ordinal_day (ordinal_day),
        .weekday     (weekday),
        .week_number (week_number)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gregorian leap rule
    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in month m (1..12); 0 for anything that is no month
    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        int unsigned lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12)
        begin
            return 0;
        end
        if (m == dcf_pkg::MONTH_FEB && leap)
        begin
            return 29;
        end
        return lengths[m-1];
    endfunction

    // Leap years in 1..n
    function automatic int unsigned leap_count(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Expected result beat for one date
    function automatic cal_fields_t calendar_fields_of(input int unsigned d,
                                                       input int unsigned m,
                                                       input int unsigned y);
        int unsigned cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        cal_fields_t res;
        bit          leap;
        int unsigned ord;
        int unsigned jan1;
        int unsigned week;
        res  = REJECTED;
        leap = is_leap_year(y);
        if (y < 1900 || d < 1 || d > days_in_month(m, leap))
        begin
            return res;
        end
        ord = cum_days[m-1] + d;
        if (leap && m > dcf_pkg::MONTH_FEB)
        begin
            ord++;
        end
        jan1 = (365 * (y - 1900) + leap_count(y - 1) - leap_count(1899)) % 7;
        week = (ord - 1 + jan1) / 7;
        // Week 1 is the week that holds the first Thursday
        if (jan1 <= dcf_pkg::WDAY_THU)
        begin
            week++;
        end
        res.valid = 1'b1;
        res.ord   = ord[dcf_pkg::OrdW-1:0];
        res.wday  = 3'((jan1 + ord - 1) % 7);
        res.week  = week[dcf_pkg::WeekW-1:0];
        return res;
    endfunction

    // Drive one date and hold it until the beat is taken
    task automatic send_date(input logic [dcf_pkg::DayW-1:0] d,
                             input logic [dcf_pkg::MonW-1:0] m,
                             input logic [dcf_pkg::YearW-1:0] y,
                             input bit fixed,
                             input cal_fields_t fixed_fields);
        start     <= 1'b1;
        day_num   <= d;
        month_num <= m;
        year_num  <= y;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_fields.push_back(fixed ? fixed_fields : calendar_fields_of(d, m, y));
        dates_sent++;
    endtask

    // Idle cycles with junk on the data ports
    task automatic idle_for(input int unsigned cycles);
        repeat (cycles)
        begin
            start     <= 1'b0;
            day_num   <= 5'($urandom);
            month_num <= 4'($urandom);
            year_num  <= 14'($urandom);
            @(posedge clk);
        end
    endtask

    // Let every outstanding result arrive
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_fields.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random date: mostly well formed, some near misses, some noise
    task automatic send_random_date();
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        pick = $urandom_range(0, 99);
        y    = ($urandom_range(0, 9) < 7) ? $urandom_range(1900, 2100)
                                          : $urandom_range(1900, 16383);
        m    = $urandom_range(1, 12);
        len  = days_in_month(m, is_leap_year(y));
        if (pick < 15)
        begin
            // month edges
            d = ($urandom_range(0, 1) == 0) ? len : $urandom_range(1, 7);
        end
        else
        begin
            d = $urandom_range(1, len);
        end
        if (pick >= 80 && pick < 85 && len < 31)
        begin
            d = len + 1;
        end
        else if (pick >= 85 && pick < 90)
        begin
            y = $urandom_range(0, 1899);
        end
        else if (pick >= 90)
        begin
            d = $urandom_range(0, 31);
            m = $urandom_range(0, 15);
            y = $urandom_range(0, 16383);
        end
        send_date(5'(d), 4'(m), 14'(y), 1'b0, REJECTED);
    endtask

    // Result checker: each done beat against the oldest expectation
    always @(posedge clk)
    begin
        cal_fields_t want;
        if (rst_n && done)
        begin
            if (pending_fields.size() == 0)
            begin
                $error("unexpected result beat: ordinal_day %0d", ordinal_day);
                fail_count++;
            end
            else
            begin
                want = pending_fields.pop_front();
                if (date_valid !== want.valid)
                begin
                    $error("date_valid mismatch: expected %0d, actual %0d", want.valid, date_valid);
                    fail_count++;
                end
                if (ordinal_day !== want.ord)
                begin
                    $error("ordinal_day mismatch: expected %0d, actual %0d", want.ord, ordinal_day);
                    fail_count++;
                end
                if (weekday !== want.wday)
                begin
                    $error("weekday mismatch: expected %0d, actual %0d", want.wday, weekday);
                    fail_count++;
                end
                if (week_number !== want.week)
                begin
                    $error("week_number mismatch: expected %0d, actual %0d",
                           want.week, week_number);
                    fail_count++;
                end
                if (want.valid)
                begin
                    valid_seen++;
                    if (want.week == 0)
                    begin
                        week0_seen++;
                    end
                    if (want.week == 53)
                    begin
                        week53_seen++;
                    end
                end
                else
                begin
                    rejected_seen++;
                end
            end
        end
    end

    // Watchdog: too long with no beat moving in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned burst;
        int unsigned gap;
        int unsigned random_sent;
        bit          paused;
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        day_num       = '0;
        month_num     = '0;
        year_num      = '0;
        fail_count    = 0;
        dates_sent    = 0;
        valid_seen    = 0;
        rejected_seen = 0;
        week0_seen    = 0;
        week53_seen   = 0;
        quiet_cycles  = 0;
        random_sent   = 0;
        paused        = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_date(directed_dates[i].day, directed_dates[i].mon, directed_dates[i].year,
                      directed_dates[i].fixed, directed_dates[i].fields);
        end
        wait_drained();

        // Random bursts with random gaps; one full drain halfway through
        while (random_sent < RANDOM_DATES)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && random_sent < RANDOM_DATES; i++)
            begin
                send_random_date();
                random_sent++;
            end
            if (!paused && random_sent >= RANDOM_DATES / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, MAX_GAP);
                idle_for(gap);
            end
        end

        wait_drained();
        idle_for(DRAIN_CYCLES);

        $display("Sent %0d dates: %0d valid, %0d rejected", dates_sent, valid_seen, rejected_seen);
        $display("Valid dates in week 0: %0d, in week 53: %0d", week0_seen, week53_seen);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dcf_pkg.sv
rtl/core/dcf_front.sv
rtl/core/dcf_check.sv
rtl/core/dcf_week.sv
rtl/core/date_to_calendar_fields.sv
bench/testbench.sv
